>>> hw/rtl/stwe_pkg.sv
`default_nettype none

package stwe_pkg;

   // Operation codes as they arrive on the request channel.
   localparam logic [2:0] OP_REGISTER = 3'd0;
   localparam logic [2:0] OP_DELETE   = 3'd1;
   localparam logic [2:0] OP_CLEAR    = 3'd2;
   localparam logic [2:0] OP_EXPIRE   = 3'd3;
   localparam logic [2:0] OP_LOOKUP   = 3'd4;
   localparam logic [2:0] OP_RENEW    = 3'd5;
   localparam logic [2:0] OP_COUNT    = 3'd6;

   localparam int ID_W    = 32;
   localparam int TIME_W  = 32;
   localparam int COUNT_W = 5;

   // What the back end has to do with a command. Count, the unused code and a
   // register of id zero all leave the table alone and only report the count.
   typedef enum logic [2:0] {
      KIND_REGISTER,
      KIND_DELETE,
      KIND_CLEAR,
      KIND_EXPIRE,
      KIND_LOOKUP,
      KIND_RENEW,
      KIND_REPORT
   } cmd_kind_type;

   // Classified command handed from the front end to the back end.
   typedef struct packed {
      cmd_kind_type      kind;
      logic              needs_scan;
      logic [ID_W-1:0]   session_id;
      logic [TIME_W-1:0] expiry_time;
      logic [TIME_W-1:0] now_time;
   } cmd_type;

   // One result item.
   typedef struct packed {
      logic               ok;
      logic               found;
      logic [TIME_W-1:0]  stored_expiry;
      logic [ID_W-1:0]    assigned_id;
      logic [COUNT_W-1:0] entry_count;
      logic               clock_wrapped;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/stwe_ram.sv
`default_nettype none

module stwe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/stwe_front.sv
`default_nettype none

module stwe_front
   import stwe_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [2:0]        req_opcode,
   input  wire logic [ID_W-1:0]   req_session_id,
   input  wire logic [TIME_W-1:0] req_expiry_time,
   input  wire logic [TIME_W-1:0] req_now_time,
   output logic                   cmd_vld,
   output cmd_type                cmd,
   input  wire logic              cmd_take
);

   localparam int QUEUE_DEPTH = 2;

   cmd_type     slot_ff [QUEUE_DEPTH];
   logic [1:0]  fill_ff, fill_in;
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic        push;
   logic        pop;
   cmd_type     new_cmd;

   // Classify the incoming item so the back end only sees what it must do.
   always_comb begin
      new_cmd.session_id  = req_session_id;
      new_cmd.expiry_time = req_expiry_time;
      new_cmd.now_time    = req_now_time;
      new_cmd.kind        = KIND_REPORT;
      new_cmd.needs_scan  = 1'b0;
      case (req_opcode)
         OP_REGISTER: begin
            if (req_session_id != '0) begin
               new_cmd.kind       = KIND_REGISTER;
               new_cmd.needs_scan = 1'b1;
            end
         end
         OP_DELETE: begin
            new_cmd.kind       = KIND_DELETE;
            new_cmd.needs_scan = 1'b1;
         end
         OP_CLEAR: begin
            new_cmd.kind = KIND_CLEAR;
         end
         OP_EXPIRE: begin
            new_cmd.kind       = KIND_EXPIRE;
            new_cmd.needs_scan = 1'b1;
         end
         OP_LOOKUP: begin
            new_cmd.kind       = KIND_LOOKUP;
            new_cmd.needs_scan = 1'b1;
         end
         OP_RENEW: begin
            new_cmd.kind       = KIND_RENEW;
            new_cmd.needs_scan = 1'b1;
         end
         OP_COUNT: begin
            new_cmd.kind = KIND_REPORT;
         end
         default: begin
            new_cmd.kind = KIND_REPORT;
         end
      endcase
   end

   // Two-entry command queue between the front and back ends.
   assign req_full = (fill_ff == 2'(QUEUE_DEPTH));
   assign cmd_vld  = (fill_ff != 2'd0);
   assign cmd      = slot_ff[rd_ptr_ff];
   assign push     = req_push && !req_full;
   assign pop      = cmd_take && cmd_vld;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/stwe_back.sv
`default_nettype none

module stwe_back
   import stwe_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_vld,
   input  wire cmd_type cmd,
   output logic         cmd_take,
   output logic         res_vld,
   output rsp_type      res,
   input  wire logic    res_pop
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } back_state_type;

   back_state_type           state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic                     wrap_ff, wrap_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [TIME_W-1:0]        last_now_ff, last_now_in;
   logic [CNT_W-1:0]         issue_ff, issue_in;
   logic                     chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]         chk_idx_ff, chk_idx_in;
   logic                     hit_ff, hit_in;
   logic [IDX_W-1:0]         hit_idx_ff, hit_idx_in;
   logic [TIME_W-1:0]        hit_exp_ff, hit_exp_in;
   logic                     free_ff, free_in;
   logic [IDX_W-1:0]         free_idx_ff, free_idx_in;
   logic                     res_vld_ff, res_vld_in;
   rsp_type                  res_ff, res_in;

   logic                     rd_en;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [ID_W-1:0]          id_rd;
   logic [TIME_W-1:0]        exp_rd;

   logic                     entry_v;
   logic                     take_wrap;
   logic                     finish_go;
   logic                     do_insert;
   logic                     do_update;
   logic                     do_delete;
   logic                     do_clear;
   logic [CNT_W-1:0]         count_after;
   logic [CNT_W+COUNT_W-1:0] count_wide;

   // Id and expiry stores, read one entry a cycle during the scan.
   stwe_ram #(.WIDTH(ID_W), .DEPTH(TABLE_ENTRIES)) u_id_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd_ff.session_id),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (id_rd)
   );

   stwe_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_ENTRIES)) u_exp_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd_ff.expiry_time),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (exp_rd)
   );

   assign entry_v   = valid_ff[chk_idx_ff];
   assign take_wrap = (cmd.kind == KIND_EXPIRE) && (cmd.now_time < last_now_ff);
   assign finish_go = !res_vld_ff || res_pop;

   // Outcome of the command once the scan has found its match and free slot.
   assign do_insert = ((cmd_ff.kind == KIND_REGISTER) || (cmd_ff.kind == KIND_RENEW))
                      && !hit_ff && free_ff;
   assign do_update = (cmd_ff.kind == KIND_RENEW) && hit_ff;
   assign do_delete = (cmd_ff.kind == KIND_DELETE) && hit_ff;
   assign do_clear  = (cmd_ff.kind == KIND_CLEAR) || wrap_ff;
   assign wr_addr   = do_update ? hit_idx_ff : free_idx_ff;

   always_comb begin
      count_after = count_ff;
      if (do_clear) begin
         count_after = '0;
      end else if (do_insert) begin
         count_after = count_ff + CNT_W'(1);
      end else if (do_delete) begin
         count_after = count_ff - CNT_W'(1);
      end
   end

   assign count_wide = {{COUNT_W{1'b0}}, count_after};

   // Sequencer: take a command, scan the table when it needs one, then commit and report.
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      wrap_in     = wrap_ff;
      valid_in    = valid_ff;
      count_in    = count_ff;
      last_now_in = last_now_ff;
      issue_in    = issue_ff;
      chk_vld_in  = chk_vld_ff;
      chk_idx_in  = chk_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_exp_in  = hit_exp_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      res_in      = res_ff;
      res_vld_in  = res_vld_ff && !res_pop;
      cmd_take    = 1'b0;
      rd_en       = 1'b0;
      wr_en       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_vld) begin
               cmd_take   = 1'b1;
               cmd_in     = cmd;
               wrap_in    = take_wrap;
               issue_in   = '0;
               chk_vld_in = 1'b0;
               hit_in     = 1'b0;
               free_in    = 1'b0;
               state_in   = (cmd.needs_scan && !take_wrap) ? ST_SCAN : ST_FINISH;
            end
         end
         ST_SCAN: begin
            // Issue the next read while the previous entry is checked.
            if (issue_ff < ENTRIES_CNT) begin
               rd_en      = 1'b1;
               issue_in   = issue_ff + CNT_W'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff[IDX_W-1:0];
            end else begin
               chk_vld_in = 1'b0;
            end
            if (chk_vld_ff) begin
               if (entry_v && (id_rd == cmd_ff.session_id) && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = chk_idx_ff;
                  hit_exp_in = exp_rd;
               end
               if (!entry_v && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
               if ((cmd_ff.kind == KIND_EXPIRE) && entry_v && (exp_rd < cmd_ff.now_time)) begin
                  valid_in[chk_idx_ff] = 1'b0;
                  count_in             = count_ff - CNT_W'(1);
               end
               if (chk_idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            // Commit only when the result register can take the item.
            if (finish_go) begin
               wr_en    = do_insert || do_update;
               count_in = count_after;
               if (do_clear) begin
                  valid_in = '0;
               end else if (do_insert) begin
                  valid_in[free_idx_ff] = 1'b1;
               end else if (do_delete) begin
                  valid_in[hit_idx_ff] = 1'b0;
               end
               if (cmd_ff.kind == KIND_EXPIRE) begin
                  last_now_in = cmd_ff.now_time;
               end
               res_in.ok            = do_insert || do_update || do_delete;
               res_in.found         = (cmd_ff.kind == KIND_LOOKUP) && hit_ff;
               res_in.stored_expiry = ((cmd_ff.kind == KIND_LOOKUP) && hit_ff) ? hit_exp_ff : '0;
               res_in.assigned_id   = ((cmd_ff.kind == KIND_REGISTER) && do_insert)
                                      ? cmd_ff.session_id : '0;
               res_in.entry_count   = count_wide[COUNT_W-1:0];
               res_in.clock_wrapped = wrap_ff;
               res_vld_in           = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= '0;
         count_ff    <= '0;
         last_now_ff <= '0;
         chk_vld_ff  <= 1'b0;
         res_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         count_ff    <= count_in;
         last_now_ff <= last_now_in;
         chk_vld_ff  <= chk_vld_in;
         res_vld_ff  <= res_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      wrap_ff     <= wrap_in;
      issue_ff    <= issue_in;
      chk_idx_ff  <= chk_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_exp_ff  <= hit_exp_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      res_ff      <= res_in;
   end

   assign res_vld = res_vld_ff;
   assign res     = res_ff;

endmodule

`default_nettype wire

>>> hw/rtl/session_table_with_expiry_core.sv
// Session table with expiry.
//
// Requests enter through a queue-like port: drive the fields and raise
// req_push; the item is taken at a clock edge where req_full is low. Results
// leave the same way: while rsp_empty is low the oldest result is on the rsp_
// ports, and raising rsp_pop takes it at that edge. Every request gives one
// result, in order.
// A two-entry command queue holds requests while the table engine works.
// Lookup, register, renew, delete and expire walk the id and expiry memories
// one entry per cycle, then commit and write the result register. Clear all,
// count, a register of id zero and an expire that sees the time go backwards
// need no walk and go straight from taking the command to the commit.
// Reset empties both queues, marks every entry invalid and zeroes the last
// seen time; the first request is taken on the cycle after reset falls.
// If the receiver does not pop, the finished result stays in its register,
// the engine holds its next result uncommitted, and the command queue keeps
// accepting until it is full.
`default_nettype none

module session_table_with_expiry_core
   import stwe_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire logic [2:0]        req_opcode,
   input  wire logic [ID_W-1:0]   req_session_id,
   input  wire logic [TIME_W-1:0] req_expiry_time,
   input  wire logic [TIME_W-1:0] req_now_time,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output logic                   rsp_ok,
   output logic                   rsp_found,
   output logic [TIME_W-1:0]      rsp_stored_expiry,
   output logic [ID_W-1:0]        rsp_assigned_id,
   output logic [COUNT_W-1:0]     rsp_entry_count,
   output logic                   rsp_clock_wrapped
);

   logic    cmd_vld;
   cmd_type cmd;
   logic    cmd_take;
   logic    res_vld;
   rsp_type res;

   // Front end: accept and classify requests.
   stwe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_session_id  (req_session_id),
      .req_expiry_time (req_expiry_time),
      .req_now_time    (req_now_time),
      .cmd_vld         (cmd_vld),
      .cmd             (cmd),
      .cmd_take        (cmd_take)
   );

   // Back end: table walk, commit and result register.
   stwe_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_vld  (cmd_vld),
      .cmd      (cmd),
      .cmd_take (cmd_take),
      .res_vld  (res_vld),
      .res      (res),
      .res_pop  (rsp_pop)
   );

   assign rsp_empty         = !res_vld;
   assign rsp_ok            = res.ok;
   assign rsp_found         = res.found;
   assign rsp_stored_expiry = res.stored_expiry;
   assign rsp_assigned_id   = res.assigned_id;
   assign rsp_entry_count   = res.entry_count;
   assign rsp_clock_wrapped = res.clock_wrapped;

endmodule

`default_nettype wire

>>> hw/rtl/stwe_checker.sv
`default_nettype none

module stwe_checker
   import stwe_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_empty,
   input wire logic              rsp_pop,
   input wire logic              rsp_ok,
   input wire logic              rsp_found,
   input wire logic [TIME_W-1:0] rsp_stored_expiry,
   input wire logic [ID_W-1:0]   rsp_assigned_id,
   input wire logic [COUNT_W-1:0] rsp_entry_count,
   input wire logic              rsp_clock_wrapped
);

   // No result is shown in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown right after reset");

   // A wrapped clock clears the table and is never a success or a hit.
   a_wrap_clears: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_clock_wrapped) |->
         (rsp_entry_count == '0) && !rsp_ok && !rsp_found)
      else $error("clock wrap reported with entries left");

   // An expiry is reported only together with a hit, and an id only on success.
   a_fields_consistent: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |->
         (rsp_found || (rsp_stored_expiry == '0)) && (rsp_ok || (rsp_assigned_id == '0)))
      else $error("result fields inconsistent");

   // A result that is not taken stays unchanged.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         !rsp_empty && $stable(rsp_ok) && $stable(rsp_found) && $stable(rsp_stored_expiry)
         && $stable(rsp_assigned_id) && $stable(rsp_entry_count) && $stable(rsp_clock_wrapped))
      else $error("stalled result changed");

endmodule

bind session_table_with_expiry_core stwe_checker u_stwe_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_ok            (rsp_ok),
   .rsp_found         (rsp_found),
   .rsp_stored_expiry (rsp_stored_expiry),
   .rsp_assigned_id   (rsp_assigned_id),
   .rsp_entry_count   (rsp_entry_count),
   .rsp_clock_wrapped (rsp_clock_wrapped)
);

`default_nettype wire

>>> tb/session_table_with_expiry_core_test.sv
`default_nettype none

module session_table_with_expiry_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   import stwe_pkg::*;

   localparam int TABLE_SIZE   = 16;
   localparam int POOL_SIZE    = 24;
   localparam int RANDOM_ITEMS = 1000;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 200;
   localparam int MAX_REPORTS  = 10;

   // The one opcode the block does not define.
   localparam logic [2:0] OP_SPARE = 3'd7;

   typedef struct {
      logic [2:0]        opcode;
      logic [ID_W-1:0]   session_id;
      logic [TIME_W-1:0] expiry_time;
      logic [TIME_W-1:0] now_time;
      int                gap;
   } cmd_item_type;

   logic clock;
   logic reset;
   logic req_push;
   logic req_full;
   logic [2:0] req_opcode;
   logic [ID_W-1:0] req_session_id;
   logic [TIME_W-1:0] req_expiry_time;
   logic [TIME_W-1:0] req_now_time;
   logic rsp_empty;
   logic rsp_pop;
   logic rsp_ok;
   logic rsp_found;
   logic [TIME_W-1:0] rsp_stored_expiry;
   logic [ID_W-1:0] rsp_assigned_id;
   logic [COUNT_W-1:0] rsp_entry_count;
   logic rsp_clock_wrapped;

   // Expected contents of the session table.
   logic [TABLE_SIZE-1:0] tbl_valid;
   logic [ID_W-1:0]       tbl_id [TABLE_SIZE];
   logic [TIME_W-1:0]     tbl_expiry [TABLE_SIZE];
   logic [TIME_W-1:0]     tbl_last_now;

   cmd_item_type pending_cmds[$];
   rsp_type      expected_rsps[$];

   int  accepted_items = 0;
   int  results_seen = 0;
   int  mismatches = 0;
   int  stall_cycles = 0;
   int  tx_wait = 0;
   int  rx_wait = 0;
   int  hold_left = 0;
   bit  pressure_done = 0;
   bit  req_taken = 0;
   bit  tx_burst = 0;

   session_table_with_expiry_core #(
      .TABLE_ENTRIES(TABLE_SIZE)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_opcode(req_opcode),
      .req_session_id(req_session_id),
      .req_expiry_time(req_expiry_time),
      .req_now_time(req_now_time),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_ok(rsp_ok),
      .rsp_found(rsp_found),
      .rsp_stored_expiry(rsp_stored_expiry),
      .rsp_assigned_id(rsp_assigned_id),
      .rsp_entry_count(rsp_entry_count),
      .rsp_clock_wrapped(rsp_clock_wrapped)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Applies one command to the expected table and returns the result it gives.
   function automatic rsp_type apply_to_table(input logic [2:0] op,
                                              input logic [ID_W-1:0] id,
                                              input logic [TIME_W-1:0] expiry,
                                              input logic [TIME_W-1:0] now_t);
      rsp_type r;
      int hit;
      int vacant;
      r = '0;
      hit = -1;
      vacant = -1;
      // Scan downward so the lowest matching and lowest free slots win.
      for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
         if (tbl_valid[i] && tbl_id[i] == id) hit = i;
         if (!tbl_valid[i]) vacant = i;
      end
      case (op)
         OP_REGISTER: begin
            if (id != '0 && hit < 0 && vacant >= 0) begin
               tbl_valid[vacant] = 1'b1;
               tbl_id[vacant] = id;
               tbl_expiry[vacant] = expiry;
               r.ok = 1'b1;
               r.assigned_id = id;
            end
         end
         OP_DELETE: begin
            if (hit >= 0) begin
               tbl_valid[hit] = 1'b0;
               r.ok = 1'b1;
            end
         end
         OP_CLEAR: begin
            tbl_valid = '0;
         end
         OP_EXPIRE: begin
            // Time going backwards means the clock wrapped: drop everything.
            if (now_t < tbl_last_now) begin
               tbl_valid = '0;
               r.clock_wrapped = 1'b1;
            end else begin
               for (int i = 0; i < TABLE_SIZE; i++)
                  if (tbl_valid[i] && tbl_expiry[i] < now_t) tbl_valid[i] = 1'b0;
            end
            tbl_last_now = now_t;
         end
         OP_LOOKUP: begin
            if (hit >= 0) begin
               r.found = 1'b1;
               r.stored_expiry = tbl_expiry[hit];
            end
         end
         OP_RENEW: begin
            if (hit >= 0) begin
               tbl_expiry[hit] = expiry;
               r.ok = 1'b1;
            end else if (vacant >= 0) begin
               tbl_valid[vacant] = 1'b1;
               tbl_id[vacant] = id;
               tbl_expiry[vacant] = expiry;
               r.ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.entry_count = COUNT_W'($countones(tbl_valid));
      return r;
   endfunction

   task automatic add_cmd(input logic [2:0] op, input logic [ID_W-1:0] id,
                          input logic [TIME_W-1:0] expiry,
                          input logic [TIME_W-1:0] now_t);
      cmd_item_type c;
      c.opcode = op;
      c.session_id = id;
      c.expiry_time = expiry;
      c.now_time = now_t;
      c.gap = tx_burst ? 0 : $urandom_range(0, 7);
      pending_cmds.push_back(c);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("result %0d: %s expected 0x%08h, got 0x%08h",
                     results_seen, name, want, got);
      end
   endtask

   // Take a snapshot of the expected result whenever the block accepts an item.
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         expected_rsps.push_back(apply_to_table(req_opcode, req_session_id,
                                                req_expiry_time, req_now_time));
         accepted_items++;
         req_taken = 1'b1;
      end
   end

   // Driver: holds an item until it is taken, then waits the next item's gap.
   always @(negedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else if (req_push && !req_taken) begin
         req_push <= 1'b1;
      end else begin
         req_taken = 1'b0;
         if (pending_cmds.size() == 0) begin
            req_push <= 1'b0;
         end else if (tx_wait < pending_cmds[0].gap) begin
            tx_wait++;
            req_push <= 1'b0;
         end else begin
            tx_wait = 0;
            req_opcode <= pending_cmds[0].opcode;
            req_session_id <= pending_cmds[0].session_id;
            req_expiry_time <= pending_cmds[0].expiry_time;
            req_now_time <= pending_cmds[0].now_time;
            req_push <= 1'b1;
            void'(pending_cmds.pop_front());
         end
      end
   end

   // Monitor: compares each result taken against the oldest expectation.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("result %0d: arrived with no item outstanding", results_seen);
         end else begin
            want = expected_rsps.pop_front();
            check_field("ok", 32'(want.ok), 32'(rsp_ok));
            check_field("found", 32'(want.found), 32'(rsp_found));
            check_field("stored_expiry", want.stored_expiry, rsp_stored_expiry);
            check_field("assigned_id", want.assigned_id, rsp_assigned_id);
            check_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
            check_field("clock_wrapped", 32'(want.clock_wrapped),
                        32'(rsp_clock_wrapped));
         end
         results_seen++;
         // Stretches of back-to-back pops between randomly stalled ones.
         rx_wait = (results_seen % 128 < 32) ? 0 : $urandom_range(0, 7);
      end
   end

   // Receiver: random stalls, plus one long hold-off that backs up the block.
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (!pressure_done && results_seen >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog on cycles in which neither side moves an item.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("session_table_with_expiry_core verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [ID_W-1:0] id_pool [POOL_SIZE];
      logic [TIME_W-1:0] sim_now;
      logic [ID_W-1:0] id;
      logic [TIME_W-1:0] expiry;
      logic [TIME_W-1:0] now_t;
      logic [2:0] op;
      int pick;
      int seg;
      int total;
      bit first_seg;

      reset = 1'b1;
      req_push = 1'b0;
      req_opcode = OP_REGISTER;
      req_session_id = '0;
      req_expiry_time = '0;
      req_now_time = '0;
      rsp_pop = 1'b0;
      tbl_valid = '0;
      tbl_last_now = '0;

      // Directed items: extremes, every operation and the corner cases.
      add_cmd(OP_COUNT, '0, '0, '0);
      add_cmd(OP_LOOKUP, '0, '0, '0);
      add_cmd(OP_REGISTER, '0, 32'd77, '0);
      add_cmd(OP_REGISTER, '1, '1, '1);
      add_cmd(OP_REGISTER, '1, 32'd5, '0);
      add_cmd(OP_LOOKUP, '1, '0, '0);
      add_cmd(OP_RENEW, '1, '0, '0);
      add_cmd(OP_RENEW, '0, 32'd12345, '0);
      add_cmd(OP_LOOKUP, '0, '0, '0);
      add_cmd(OP_DELETE, '0, '0, '0);
      add_cmd(OP_DELETE, '0, '0, '0);
      add_cmd(OP_REGISTER, 32'd9, 32'd100, '0);
      // Expiry below now goes, equal stays; an equal time is not a wrap.
      add_cmd(OP_EXPIRE, '0, '0, 32'd100);
      add_cmd(OP_EXPIRE, '0, '0, 32'd100);
      add_cmd(OP_LOOKUP, 32'd9, '0, '0);
      add_cmd(OP_EXPIRE, '0, '0, 32'd50);
      add_cmd(OP_REGISTER, 32'd3, '1, '0);
      add_cmd(OP_EXPIRE, '0, '0, '1);
      add_cmd(OP_EXPIRE, '0, '0, '0);
      add_cmd(OP_RENEW, 32'd4, 32'd8, '1);
      add_cmd(OP_SPARE, '1, '1, '1);
      add_cmd(OP_CLEAR, '1, '1, '1);
      add_cmd(OP_COUNT, '1, '1, '1);

      // A small id pool keeps hits, duplicates and a full table common.
      for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = $urandom | 32'd1;
      id_pool[POOL_SIZE-1] = '0;
      id_pool[POOL_SIZE-2] = '1;
      sim_now = 32'd1000;
      first_seg = 1'b1;

      while (pending_cmds.size() < RANDOM_ITEMS + 25) begin
         seg = $urandom_range(0, 9);
         tx_burst = ($urandom_range(0, 3) == 0);
         if (first_seg || seg == 0) begin
            // Fill the table from empty, overflow it, then probe it.
            add_cmd(OP_CLEAR, $urandom, $urandom, $urandom);
            for (int k = 0; k <= TABLE_SIZE; k++)
               add_cmd(OP_REGISTER, id_pool[k], sim_now + $urandom_range(0, 400),
                       $urandom);
            add_cmd(OP_RENEW, id_pool[POOL_SIZE-3], $urandom, $urandom);
            add_cmd(OP_LOOKUP, id_pool[$urandom_range(0, TABLE_SIZE - 1)],
                    $urandom, $urandom);
         end else if (seg == 1) begin
            // Noise: every field fully random.
            for (int k = 0; k < 10; k++)
               add_cmd(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
         end else begin
            for (int k = 0; k < 20; k++) begin
               pick = $urandom_range(0, 99);
               if (pick < 25) op = OP_REGISTER;
               else if (pick < 40) op = OP_RENEW;
               else if (pick < 60) op = OP_LOOKUP;
               else if (pick < 75) op = OP_DELETE;
               else if (pick < 87) op = OP_EXPIRE;
               else if (pick < 92) op = OP_COUNT;
               else if (pick < 96) op = OP_CLEAR;
               else op = OP_SPARE;
               id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                 : $urandom;
               expiry = ($urandom_range(0, 99) < 80) ? sim_now + $urandom_range(0, 400)
                                                     : $urandom;
               now_t = $urandom;
               // Expire mostly moves time forward, sometimes back or anywhere.
               if (op == OP_EXPIRE) begin
                  pick = $urandom_range(0, 9);
                  if (pick < 8) now_t = sim_now + $urandom_range(0, 60);
                  else if (pick == 8) now_t = sim_now - $urandom_range(1, 200);
                  sim_now = now_t;
               end
               add_cmd(op, id, expiry, now_t);
            end
         end
         first_seg = 1'b0;
      end
      total = pending_cmds.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (accepted_items == total);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("session_table_with_expiry_core verification clean");
      end else begin
         $display("session_table_with_expiry_core verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
